FILE: rtl/core/pfba_pkg.sv
// ----------------------------------------------------------------------------
// pfba_pkg
// Shared constants for the page frame bitmap allocator: map geometry, field
// widths, opcodes, register indexes and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package pfba_pkg;

	// Map geometry: one bit per 4 KiB frame, packed into words.
	localparam int NUM_FRAMES    = 65536;
	localparam int MAP_WORD_BITS = 32;
	localparam int MAP_WORDS     = (NUM_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int WORD_IDX_W    = $clog2(MAP_WORDS);
	localparam int BIT_IDX_W     = $clog2(MAP_WORD_BITS);
	localparam int FRAME_NUM_W   = WORD_IDX_W + BIT_IDX_W;

	// Field widths.
	localparam int REG_W        = 17;
	localparam int ADDR_IN_W    = 32;
	localparam int ADDR_OUT_W   = 28;
	localparam int FRAME_SHIFT  = 12;
	localparam int FREE_FRAME_W = ADDR_IN_W - FRAME_SHIFT;
	localparam int STATUS_W     = 3;
	localparam int CFG_IDX_W    = 2;

	// Request opcodes.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MAX = 2'd1;

	// Register reset values.
	localparam logic [REG_W-1:0] FRAME_MIN_RST = 17'd0;
	localparam logic [REG_W-1:0] FRAME_MAX_RST = 17'd65536;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_ALLOCATED     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NONE_FREE     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_RELEASED      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_OUT_OF_WINDOW = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ALREADY_FREE  = 3'd4;

endpackage

`default_nettype wire

FILE: rtl/core/pfba_intf.sv
// ----------------------------------------------------------------------------
// pfba_intf
// Valid/ready channels of the page frame bitmap allocator: request beats,
// result beats and configuration write beats.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel: one beat per allocate or free request.
interface pfba_req_if;
	logic                           valid;
	logic                           ready;
	logic                           opcode;
	logic [pfba_pkg::ADDR_IN_W-1:0] free_address;

	modport source (output valid, output opcode, output free_address, input ready);
	modport sink   (input valid, input opcode, input free_address, output ready);
endinterface

// Result channel: one beat per request.
interface pfba_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [pfba_pkg::ADDR_OUT_W-1:0] frame_address;
	logic [pfba_pkg::STATUS_W-1:0]   status;
	logic [pfba_pkg::REG_W-1:0]      frames_in_use;

	modport source (output valid, output frame_address, output status,
		output frames_in_use, input ready);
	modport sink   (input valid, input frame_address, input status,
		input frames_in_use, output ready);
endinterface

// Configuration write channel.
interface pfba_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [pfba_pkg::CFG_IDX_W-1:0] index;
	logic [pfba_pkg::REG_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/page_frame_bitmap_allocator_unit.sv
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_unit
// First-fit page frame allocator over a one-bit-per-frame used map.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request per beat: opcode allocate or free, and the byte
//   address to release for a free. rsp returns exactly one beat per request
//   with the allocated byte address, a status code and the frames-in-use
//   count. cfg writes frame_min (index 0) and frame_max (index 1); it is
//   always ready. The user must write it only while the block is idle; the
//   block itself does not enforce this. The used map is a 2048 x 32
//   single-port memory. An allocate scans it one word at a time from the
//   word holding frame_min, 1 to 2048 words in all; each word takes a
//   registered read, then a test and write back. A free reads one word; a
//   free outside the window and an allocate on an empty window answer in
//   the next cycle. One request is in progress at a time: req.ready is low
//   from acceptance until the result beat has been taken, and rises again
//   at the edge that takes it.
//   After reset a clearing pass writes every map word to zero, one word a
//   cycle; req.ready stays low throughout the pass. A stalled result holds
//   rsp and the block until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module page_frame_bitmap_allocator_unit (
	input  wire          clk,
	input  wire          arst_n,
	pfba_req_if.sink     req,
	pfba_rsp_if.source   rsp,
	pfba_cfg_if.sink     cfg
);

	localparam int W  = pfba_pkg::MAP_WORD_BITS;
	localparam int WI = pfba_pkg::WORD_IDX_W;
	localparam int BI = pfba_pkg::BIT_IDX_W;
	localparam int FN = pfba_pkg::FRAME_NUM_W;
	localparam int RW = pfba_pkg::REG_W;
	localparam int FF = pfba_pkg::FREE_FRAME_W;

	// Sequencer states.
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_EVAL  = 3'd3;
	localparam logic [2:0] S_RESP  = 3'd4;

	logic [2:0]                      state_q;
	logic [RW-1:0]                   frame_min_q;
	logic [RW-1:0]                   frame_max_q;
	logic [RW-1:0]                   count_q;
	logic                            op_q;
	logic [WI-1:0]                   word_q;
	logic [WI-1:0]                   first_w_q;
	logic [WI-1:0]                   last_w_q;
	logic [BI-1:0]                   lo_bit_q;
	logic [BI-1:0]                   hi_bit_q;
	logic [BI-1:0]                   bit_q;
	logic [pfba_pkg::ADDR_OUT_W-1:0] addr_q;
	logic [pfba_pkg::STATUS_W-1:0]   status_q;

	logic [W-1:0] map_mem [pfba_pkg::MAP_WORDS];
	logic [W-1:0] map_rdata_q;
	logic         mem_we;
	logic [W-1:0] mem_wdata;

	logic [RW-1:0] hi_eff;
	logic [RW-1:0] hi_m1;
	logic [FF-1:0] free_frame;
	logic          free_in_win;
	logic          win_empty;
	logic [W-1:0]  lo_mask;
	logic [W-1:0]  hi_mask;
	logic [W-1:0]  zeros;
	logic [W-1:0]  low_zero;
	logic          hit;
	logic [BI-1:0] hit_idx;
	logic [W-1:0]  free_mask;
	logic          free_bit_set;
	logic [FN-1:0] hit_frame;

	// Window bound and request decode, evaluated while idle.
	always_comb begin
		hi_eff = (frame_max_q < RW'(pfba_pkg::NUM_FRAMES)) ? frame_max_q
			: RW'(pfba_pkg::NUM_FRAMES);
		hi_m1       = hi_eff - RW'(1);
		win_empty   = (frame_min_q >= hi_eff);
		free_frame  = req.free_address[pfba_pkg::ADDR_IN_W-1:pfba_pkg::FRAME_SHIFT];
		free_in_win = (free_frame >= FF'(frame_min_q)) && (free_frame < FF'(hi_eff));
	end

	// Word test: mask bits outside the window and isolate the lowest free bit.
	always_comb begin
		lo_mask   = (word_q == first_w_q) ? ~({W{1'b1}} << lo_bit_q) : '0;
		hi_mask   = (word_q == last_w_q) ? (({W{1'b1}} << hi_bit_q) << 1) : '0;
		zeros     = ~(map_rdata_q | lo_mask | hi_mask);
		low_zero  = zeros & (~zeros + W'(1));
		hit       = |zeros;
		hit_idx   = '0;
		for (int i = 0; i < W; i++) begin
			if (low_zero[i]) begin
				hit_idx = hit_idx | BI'(i);
			end
		end
		hit_frame    = {word_q, hit_idx};
		free_mask    = W'(1) << bit_q;
		free_bit_set = |(map_rdata_q & free_mask);
	end

	// Map write port: clearing pass, allocate set or free clear.
	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = '0;
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
		end else if (state_q == S_EVAL) begin
			if (op_q == pfba_pkg::OP_ALLOC) begin
				mem_we    = hit;
				mem_wdata = map_rdata_q | low_zero;
			end else begin
				mem_we    = free_bit_set;
				mem_wdata = map_rdata_q & ~free_mask;
			end
		end
	end

	// Used map memory with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[word_q] <= mem_wdata;
		end
		map_rdata_q <= map_mem[word_q];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_min_q <= pfba_pkg::FRAME_MIN_RST;
			frame_max_q <= pfba_pkg::FRAME_MAX_RST;
		end else if (cfg.valid) begin
			if (cfg.index == pfba_pkg::CFG_FRAME_MIN) begin
				frame_min_q <= cfg.data;
			end else if (cfg.index == pfba_pkg::CFG_FRAME_MAX) begin
				frame_max_q <= cfg.data;
			end
		end
	end

	// Sequencer: clearing pass, word scan, result hand-off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			word_q    <= '0;
			count_q   <= '0;
			op_q      <= pfba_pkg::OP_ALLOC;
			first_w_q <= '0;
			last_w_q  <= '0;
			lo_bit_q  <= '0;
			hi_bit_q  <= '0;
			bit_q     <= '0;
			addr_q    <= '0;
			status_q  <= pfba_pkg::ST_ALLOCATED;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					word_q <= word_q + WI'(1);
					if (word_q == WI'(pfba_pkg::MAP_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						op_q   <= req.opcode;
						addr_q <= '0;
						if (req.opcode == pfba_pkg::OP_ALLOC) begin
							word_q    <= frame_min_q[FN-1:BI];
							first_w_q <= frame_min_q[FN-1:BI];
							last_w_q  <= hi_m1[FN-1:BI];
							lo_bit_q  <= frame_min_q[BI-1:0];
							hi_bit_q  <= hi_m1[BI-1:0];
							if (win_empty) begin
								status_q <= pfba_pkg::ST_NONE_FREE;
								state_q  <= S_RESP;
							end else begin
								state_q <= S_READ;
							end
						end else begin
							word_q <= free_frame[FN-1:BI];
							bit_q  <= free_frame[BI-1:0];
							if (free_in_win) begin
								state_q <= S_READ;
							end else begin
								status_q <= pfba_pkg::ST_OUT_OF_WINDOW;
								state_q  <= S_RESP;
							end
						end
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (op_q == pfba_pkg::OP_ALLOC) begin
						if (hit) begin
							count_q  <= count_q + RW'(1);
							addr_q   <= pfba_pkg::ADDR_OUT_W'(
								{hit_frame, {pfba_pkg::FRAME_SHIFT{1'b0}}});
							status_q <= pfba_pkg::ST_ALLOCATED;
							state_q  <= S_RESP;
						end else if (word_q == last_w_q) begin
							status_q <= pfba_pkg::ST_NONE_FREE;
							state_q  <= S_RESP;
						end else begin
							word_q  <= word_q + WI'(1);
							state_q <= S_READ;
						end
					end else begin
						if (free_bit_set) begin
							if (count_q != '0) begin
								count_q <= count_q - RW'(1);
							end
							status_q <= pfba_pkg::ST_RELEASED;
						end else begin
							status_q <= pfba_pkg::ST_ALREADY_FREE;
						end
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Channel outputs.
	assign req.ready         = (state_q == S_IDLE);
	assign cfg.ready         = 1'b1;
	assign rsp.valid         = (state_q == S_RESP);
	assign rsp.frame_address = addr_q;
	assign rsp.status        = status_q;
	assign rsp.frames_in_use = count_q;

endmodule

`default_nettype wire

FILE: rtl/core/pfba_checker.sv
// ----------------------------------------------------------------------------
// pfba_checker
// Port-level checks for the page frame bitmap allocator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module pfba_checker (
	input wire                                  clk,
	input wire                                  arst_n,
	input wire                                  req_valid,
	input wire                                  req_ready,
	input wire                                  rsp_valid,
	input wire                                  rsp_ready,
	input wire [pfba_pkg::ADDR_OUT_W-1:0]       rsp_frame_address,
	input wire [pfba_pkg::STATUS_W-1:0]         rsp_status,
	input wire [pfba_pkg::REG_W-1:0]            rsp_frames_in_use
);

	// A stalled result beat holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_address)
			&& $stable(rsp_status) && $stable(rsp_frames_in_use))
		else $error("result beat changed while stalled");

	// No new request is taken while a result is still pending.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("request accepted with a result pending");

	// Only a successful allocation carries a non-zero address.
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != pfba_pkg::ST_ALLOCATED) |-> rsp_frame_address == '0)
		else $error("non-zero address without an allocation");

	// After an allocation at least one frame is in use.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == pfba_pkg::ST_ALLOCATED) |-> rsp_frames_in_use != '0)
		else $error("allocation reported with no frame in use");

endmodule

bind page_frame_bitmap_allocator_unit pfba_checker u_pfba_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_frame_address (rsp.frame_address),
	.rsp_status        (rsp.status),
	.rsp_frames_in_use (rsp.frames_in_use)
);

`default_nettype wire
